[rtl/rdts_pkg.sv]
// ----------------------------------------------------------------------------
// rdts_pkg
// shared types and constants of the rc discharge time sequencer
// ----------------------------------------------------------------------------
package rdts_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int SHIFT_W     = 4;
  localparam int MAX_SHIFT   = 8;
  localparam int ROUND_W     = MAX_SHIFT + 1;
  localparam int SUM_W       = 32;
  localparam int INDEX_W     = 2;
  localparam int PIN_W       = 2;
  localparam int PHASE_W     = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CHG_POS = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DISCH   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHG_NEG = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BAL     = 3'd4;

  localparam logic [PIN_W-1:0] PIN_HIZ  = 2'd0;
  localparam logic [PIN_W-1:0] PIN_LOW  = 2'd1;
  localparam logic [PIN_W-1:0] PIN_HIGH = 2'd2;

  localparam logic [INDEX_W-1:0] REG_CHARGE  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_SHIFT   = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] CHARGE_RST  = 24'd6400;
  localparam logic [COUNT_WIDTH-1:0] TIMEOUT_RST = 24'd160000;
  localparam logic [SHIFT_W-1:0]     SHIFT_RST   = 4'd4;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] charge_ticks;
    logic [COUNT_WIDTH-1:0] timeout_ticks;
    logic [SHIFT_W-1:0]     sample_shift;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0]       cap_pos_drive;
    logic [PIN_W-1:0]       cap_neg_drive;
    logic [PIN_W-1:0]       probe_drive;
    logic                   busy_res;
    logic                   done_res;
    logic [COUNT_WIDTH-1:0] average;
  } res_t;

endpackage

[rtl/rdts_if.sv]
// ----------------------------------------------------------------------------
// rdts channel interfaces
// tick input, result output and register write channels
// ----------------------------------------------------------------------------
interface rdts_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic cap_level;
  modport source (output valid, output start_req, output cap_level, input ready);
  modport sink   (input valid, input start_req, input cap_level, output ready);
endinterface

interface rdts_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [rdts_pkg::PIN_W-1:0]            cap_pos_drive;
  logic [rdts_pkg::PIN_W-1:0]            cap_neg_drive;
  logic [rdts_pkg::PIN_W-1:0]            probe_drive;
  logic                                  busy_res;
  logic                                  done_res;
  logic [rdts_pkg::COUNT_WIDTH-1:0]      average;
  modport source (output valid, output cap_pos_drive, output cap_neg_drive,
                  output probe_drive, output busy_res, output done_res,
                  output average, input ready);
  modport sink   (input valid, input cap_pos_drive, input cap_neg_drive,
                  input probe_drive, input busy_res, input done_res,
                  input average, output ready);
endinterface

interface rdts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rdts_pkg::INDEX_W-1:0]     index;
  logic [rdts_pkg::COUNT_WIDTH-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rdts_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rdts_cfg_regs
// configuration register file written through the register channel
// ----------------------------------------------------------------------------
module rdts_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  rdts_cfg_if.sink             cfg,
  output rdts_pkg::cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.charge_ticks  <= rdts_pkg::CHARGE_RST;
      regs.timeout_ticks <= rdts_pkg::TIMEOUT_RST;
      regs.sample_shift  <= rdts_pkg::SHIFT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        rdts_pkg::REG_CHARGE:  regs.charge_ticks  <= cfg.data;
        rdts_pkg::REG_TIMEOUT: regs.timeout_ticks <= cfg.data;
        rdts_pkg::REG_SHIFT:   regs.sample_shift  <= cfg.data[rdts_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/rdts_seq.sv]
// ----------------------------------------------------------------------------
// rdts_seq
// round and stage sequencer: state registers and per-tick result logic
// ----------------------------------------------------------------------------
module rdts_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  rdts_pkg::cfg_t       regs,
  input  logic                 accept,
  input  logic                 start_req,
  input  logic                 cap_level,
  output rdts_pkg::res_t       res
);

  localparam int CW = rdts_pkg::COUNT_WIDTH;
  localparam int RW = rdts_pkg::ROUND_W;
  localparam int SW = rdts_pkg::SUM_W;

  logic [rdts_pkg::PHASE_W-1:0] phase, phase_next, ph_w;
  logic [CW-1:0]                stage_ticks, stage_ticks_next;
  logic [CW-1:0]                measured_ticks, measured_ticks_next, meas_w;
  logic [RW-1:0]                round_count, round_count_next, round_w;
  logic [SW-1:0]                tick_sum, tick_sum_next, sum_w;
  logic                         prev_level;
  logic [CW-1:0]                last_average, last_average_next;

  logic [CW:0]                  next_cnt;
  logic                         fall;
  logic [rdts_pkg::SHIFT_W-1:0] sh_eff;
  logic [SW:0]                  sum_add;
  logic [CW-1:0]                bal_len;
  logic [RW-1:0]                round_inc, round_lim;

  always_comb begin
    sh_eff = (regs.sample_shift > rdts_pkg::SHIFT_W'(rdts_pkg::MAX_SHIFT))
             ? rdts_pkg::SHIFT_W'(rdts_pkg::MAX_SHIFT) : regs.sample_shift;
    fall   = prev_level & ~cap_level;

    // start in idle resets the burst and counts this tick as the first
    ph_w     = phase;
    meas_w   = measured_ticks;
    round_w  = round_count;
    sum_w    = tick_sum;
    next_cnt = {1'b0, stage_ticks} + (CW+1)'(1);
    if (phase == rdts_pkg::PH_IDLE && start_req) begin
      ph_w     = rdts_pkg::PH_CHG_POS;
      meas_w   = '0;
      round_w  = '0;
      sum_w    = '0;
      next_cnt = (CW+1)'(1);
    end

    sum_add   = {1'b0, sum_w} + (SW+1)'(next_cnt);
    bal_len   = (meas_w != '0) ? meas_w : regs.timeout_ticks;
    round_inc = round_w + RW'(1);
    round_lim = RW'(1) << sh_eff;

    phase_next          = ph_w;
    stage_ticks_next    = next_cnt[CW-1:0];
    measured_ticks_next = meas_w;
    round_count_next    = round_w;
    tick_sum_next       = sum_w;
    last_average_next   = last_average;

    res.cap_pos_drive = rdts_pkg::PIN_HIZ;
    res.cap_neg_drive = rdts_pkg::PIN_HIZ;
    res.probe_drive   = rdts_pkg::PIN_HIZ;
    res.busy_res      = 1'b1;
    res.done_res      = 1'b0;

    case (ph_w)
      rdts_pkg::PH_CHG_POS: begin
        res.cap_pos_drive = rdts_pkg::PIN_HIGH;
        res.cap_neg_drive = rdts_pkg::PIN_LOW;
        if (next_cnt >= {1'b0, regs.charge_ticks}) begin
          phase_next       = rdts_pkg::PH_DISCH;
          stage_ticks_next = '0;
        end
      end
      rdts_pkg::PH_DISCH: begin
        res.cap_neg_drive = rdts_pkg::PIN_LOW;
        res.probe_drive   = rdts_pkg::PIN_LOW;
        if (next_cnt > {1'b0, regs.timeout_ticks}) begin
          measured_ticks_next = '0;
          phase_next          = rdts_pkg::PH_CHG_NEG;
          stage_ticks_next    = '0;
        end else if (fall) begin
          measured_ticks_next = next_cnt[CW-1:0];
          tick_sum_next       = sum_add[SW] ? '1 : sum_add[SW-1:0];
          phase_next          = rdts_pkg::PH_CHG_NEG;
          stage_ticks_next    = '0;
        end
      end
      rdts_pkg::PH_CHG_NEG: begin
        res.cap_pos_drive = rdts_pkg::PIN_LOW;
        res.cap_neg_drive = rdts_pkg::PIN_HIGH;
        if (next_cnt >= {1'b0, regs.charge_ticks}) begin
          phase_next       = rdts_pkg::PH_BAL;
          stage_ticks_next = '0;
        end
      end
      rdts_pkg::PH_BAL: begin
        res.cap_neg_drive = rdts_pkg::PIN_HIGH;
        res.probe_drive   = rdts_pkg::PIN_HIGH;
        if (next_cnt >= {1'b0, bal_len}) begin
          stage_ticks_next = '0;
          round_count_next = round_inc;
          if (round_inc >= round_lim) begin
            last_average_next = CW'(sum_w >> sh_eff);
            res.done_res      = 1'b1;
            phase_next        = rdts_pkg::PH_IDLE;
          end else begin
            phase_next = rdts_pkg::PH_CHG_POS;
          end
        end
      end
      default: begin
        res.busy_res     = 1'b0;
        phase_next       = rdts_pkg::PH_IDLE;
        stage_ticks_next = '0;
      end
    endcase

    res.average = last_average_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rdts_pkg::PH_IDLE;
      stage_ticks    <= '0;
      measured_ticks <= '0;
      round_count    <= '0;
      tick_sum       <= '0;
      prev_level     <= 1'b0;
      last_average   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      stage_ticks    <= stage_ticks_next;
      measured_ticks <= measured_ticks_next;
      round_count    <= round_count_next;
      tick_sum       <= tick_sum_next;
      prev_level     <= cap_level;
      last_average   <= last_average_next;
    end
  end

endmodule

[rtl/rdts_out_stage.sv]
// ----------------------------------------------------------------------------
// rdts_out_stage
// result register with valid and backpressure toward the tick input
// ----------------------------------------------------------------------------
module rdts_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rdts_pkg::res_t       res,
  output logic                 room,
  rdts_out_if.source           result
);

  logic           valid;
  rdts_pkg::res_t data;

  assign room = ~valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.valid         = valid;
  assign result.cap_pos_drive = data.cap_pos_drive;
  assign result.cap_neg_drive = data.cap_neg_drive;
  assign result.probe_drive   = data.probe_drive;
  assign result.busy_res      = data.busy_res;
  assign result.done_res      = data.done_res;
  assign result.average       = data.average;

endmodule

[rtl/rc_discharge_time_sequencer_core.sv]
// ----------------------------------------------------------------------------
// rc_discharge_time_sequencer_core
// rc discharge time sequencer: pin drive pattern and averaged edge count
// ----------------------------------------------------------------------------
// result: the result of a tick is registered and valid in the cycle after its transfer
// throughput: one tick per cycle while results are taken, set by the single result register
// the next tick is taken while a result waits if the sink takes it that cycle
// reset: synchronous, clears sequencer state, registers to defaults, no result
// ----------------------------------------------------------------------------
module rc_discharge_time_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  rdts_in_if.sink    item,
  rdts_out_if.source result,
  rdts_cfg_if.sink   cfg
);

  rdts_pkg::cfg_t regs;
  rdts_pkg::res_t res;
  logic           room;
  logic           accept;

  assign item.ready = room;
  assign accept     = item.valid & room;

  rdts_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rdts_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .accept    (accept),
    .start_req (item.start_req),
    .cap_level (item.cap_level),
    .res       (res)
  );

  rdts_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .res    (res),
    .room   (room),
    .result (result)
  );

endmodule

[rtl/rdts_checker.sv]
// ----------------------------------------------------------------------------
// rdts_checker
// port level checks of the sequencer, bound to the top level
// ----------------------------------------------------------------------------
module rdts_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [rdts_pkg::PIN_W-1:0]       cap_pos_drive,
  input logic [rdts_pkg::PIN_W-1:0]       cap_neg_drive,
  input logic [rdts_pkg::PIN_W-1:0]       probe_drive,
  input logic                             busy_res,
  input logic                             done_res,
  input logic [rdts_pkg::COUNT_WIDTH-1:0] average
);

  // a done tick always belongs to a burst
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> busy_res)
    else $error("done without busy");

  // idle ticks leave every pin floating
  a_idle_hiz: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |->
      cap_pos_drive == rdts_pkg::PIN_HIZ && cap_neg_drive == rdts_pkg::PIN_HIZ &&
      probe_drive == rdts_pkg::PIN_HIZ)
    else $error("pins driven while idle");

  // no room for a tick while a result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !item_ready)
    else $error("tick taken over a stalled result");

  // a stalled result holds its average
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(average))
    else $error("stalled result changed");

endmodule

bind rc_discharge_time_sequencer_core rdts_checker u_rdts_checker (
  .clk           (clk),
  .rst           (rst),
  .item_ready    (item.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .cap_pos_drive (result.cap_pos_drive),
  .cap_neg_drive (result.cap_neg_drive),
  .probe_drive   (result.probe_drive),
  .busy_res      (result.busy_res),
  .done_res      (result.done_res),
  .average       (result.average)
);
